// ===== src/trss_pkg.sv =====
// Shared types, codes and helpers for the thread ready/sleep scheduler.
// No dependencies.
package trss_pkg;

	localparam int THREAD_COUNT = 16;
	localparam int TID_W = 4;
	localparam int CNT_W = 5;
	localparam int TICK_W = 32;
	localparam int CRED_W = 8;

	typedef logic [TID_W-1:0] tid_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [THREAD_COUNT-1:0][TID_W-1:0] qarr_t;

	localparam logic [2:0] ST_UNKNOWN    = 3'd0;
	localparam logic [2:0] ST_ACTIVE     = 3'd1;
	localparam logic [2:0] ST_READY      = 3'd2;
	localparam logic [2:0] ST_SUSPENDING = 3'd3;
	localparam logic [2:0] ST_SUSPENDED  = 3'd4;
	localparam logic [2:0] ST_SLEEPING   = 3'd5;
	localparam logic [2:0] ST_FINALIZED  = 3'd6;

	localparam logic [2:0] REQ_TICK      = 3'd0;
	localparam logic [2:0] REQ_RESCHED   = 3'd1;
	localparam logic [2:0] REQ_ENABLE    = 3'd2;
	localparam logic [2:0] REQ_SUSPEND   = 3'd3;
	localparam logic [2:0] REQ_RESUME    = 3'd4;
	localparam logic [2:0] REQ_SLEEP     = 3'd5;
	localparam logic [2:0] REQ_FINALIZE  = 3'd6;
	localparam logic [2:0] REQ_RES_TICK  = 3'd7;

	typedef enum logic [1:0] {
		Q_NONE,
		Q_REMOVE,
		Q_PUSH_BACK,
		Q_PUSH_FRONT
	} qop_t;

	typedef struct packed {
		qop_t op;
		tid_t id;
	} qcmd_t;

	function automatic logic q_has(qarr_t q, cnt_t n, tid_t id);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < THREAD_COUNT; i++) begin
			if (CNT_W'(i) < n && q[i] == id)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ===== src/trss_q_cell.sv =====
// One slot of an ordered thread queue; removal closes the gap from the right,
// front insertion shifts in from the left. Depends on trss_pkg.
module trss_q_cell import trss_pkg::*; (
	input  logic  clk,
	input  qcmd_t cmd,
	input  cnt_t  slot,
	input  cnt_t  ins_at,
	input  logic  ins_ok,
	input  logic  live,
	input  logic  hit_in,
	input  tid_t  from_right,
	input  tid_t  shifted_left,
	output tid_t  ent,
	output tid_t  shifted,
	output logic  hit_out
);
	tid_t ent_q;
	tid_t ent_d;

	assign ent = ent_q;
	assign hit_out = hit_in | (live && ent_q == cmd.id);
	assign shifted = hit_out ? from_right : ent_q;

	always_comb begin
		ent_d = ent_q;
		case (cmd.op)
			Q_REMOVE: ent_d = shifted;
			Q_PUSH_BACK: ent_d = (ins_ok && slot == ins_at) ? cmd.id : shifted;
			Q_PUSH_FRONT: begin
				if (ins_ok)
					ent_d = (slot == '0) ? cmd.id : shifted_left;
				else
					ent_d = shifted;
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end
endmodule

// ===== src/trss_queue.sv =====
// Ordered queue of distinct thread ids built from a row of trss_q_cell.
// Depends on trss_pkg and trss_q_cell.
module trss_queue import trss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  qcmd_t cmd,
	output qarr_t ents,
	output cnt_t  count
);
	cnt_t cnt_q;
	logic [THREAD_COUNT:0] hit;
	qarr_t shf;
	cnt_t rest;
	logic ins_ok;

	assign hit[0] = 1'b0;
	assign rest = cnt_q - CNT_W'(hit[THREAD_COUNT]);
	assign ins_ok = rest < CNT_W'(THREAD_COUNT);
	assign count = cnt_q;

	for (genvar i = 0; i < THREAD_COUNT; i++) begin : g_cell
		tid_t rgt, lft;
		if (i == THREAD_COUNT - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_mid
			assign rgt = ents[i+1];
		end
		if (i == 0) begin : g_first
			assign lft = '0;
		end else begin : g_next
			assign lft = shf[i-1];
		end
		trss_q_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.slot        (CNT_W'(i)),
			.ins_at      (rest),
			.ins_ok      (ins_ok),
			.live        (CNT_W'(i) < cnt_q),
			.hit_in      (hit[i]),
			.from_right  (rgt),
			.shifted_left(lft),
			.ent         (ents[i]),
			.shifted     (shf[i]),
			.hit_out     (hit[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				Q_REMOVE: cnt_q <= rest;
				Q_PUSH_BACK, Q_PUSH_FRONT: cnt_q <= ins_ok ? rest + 1'b1 : rest;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== src/thread_ready_sleep_scheduler_core.sv =====
// Thread scheduler: per-thread table, ready FIFO and sleep list.
// Depends on trss_pkg and trss_queue.
//
// Usage: one request word on the input channel (in_valid/in_ready) gives
// exactly one result word on the output channel (out_valid/out_ready).
// in_ready is high only while the sequencer is idle, so one request is in
// work at a time. A request that needs no reschedule passes from idle
// through execute and done. A reschedule adds the wake scan, the requeue
// and the pick, with a decrement step first for a tick; the wake scan
// visits each sleep list entry (at most 15, the idle thread never sleeps).
// The result sits in an output register; the next request is taken while
// it waits. If the receiver stalls, the following result holds back the
// sequencer until the register frees.
// Reset: thread 1 is active and running, both queues are empty, all
// countdowns, flags and wake credits are zero, no result is pending.
module thread_ready_sleep_scheduler_core import trss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        req_type,
	input  logic [TID_W-1:0]  thread_id,
	input  logic              prepend,
	input  logic [TICK_W-1:0] sleep_ticks,
	input  logic              interruptible,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TID_W-1:0]  running_id,
	output logic              switched,
	output logic              accepted,
	output logic [TICK_W-1:0] ticks_left
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_DEC  = 7'b0000100,
		S_WAKE = 7'b0001000,
		S_REQ  = 7'b0010000,
		S_PICK = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [2:0]        st_q   [THREAD_COUNT];
	logic [TICK_W-1:0] cd_q   [THREAD_COUNT];
	logic              intr_q [THREAD_COUNT];
	logic [CRED_W-1:0] cred_q [THREAD_COUNT];

	tid_t run_q;
	logic rv_q;
	tid_t prev_q;
	logic pv_q;

	logic [2:0]        req_q;
	tid_t              id_q;
	logic              front_q;
	logic [TICK_W-1:0] ticks_q;
	logic              irq_q;
	logic              acc_q;
	logic [TICK_W-1:0] left_q;
	cnt_t              scan_q;

	logic              ov_q;
	tid_t              o_run_q;
	logic              o_sw_q;
	logic              o_acc_q;
	logic [TICK_W-1:0] o_left_q;

	qcmd_t rcmd, scmd;
	qarr_t rq, sq;
	cnt_t  rcnt, scnt;

	trss_queue u_ready (.clk(clk), .arst_n(arst_n), .cmd(rcmd), .ents(rq), .count(rcnt));
	trss_queue u_sleep (.clk(clk), .arst_n(arst_n), .cmd(scmd), .ents(sq), .count(scnt));

	// table write ports, one entry each, plus dec_all for the sleep list countdowns
	logic              st_we, cd_we, in_we, cr_we;
	tid_t              st_wa, cd_wa, in_wa;
	logic [2:0]        st_wd;
	logic [TICK_W-1:0] cd_wd;
	logic              in_wd;
	logic [CRED_W-1:0] cr_wd;
	logic              dec_all;
	logic              acc_set, left_we, scan_inc, rv_clr, run_we;
	logic [TICK_W-1:0] left_wd;
	tid_t              run_wd;

	logic [2:0]        s_cur;
	logic [CRED_W-1:0] c_cur, c_dec;
	logic              is_run, in_r, in_s, found, slp_path;
	tid_t              wt;
	logic              out_load;

	assign s_cur  = st_q[id_q];
	assign c_cur  = cred_q[id_q];
	assign c_dec  = (c_cur != '0) ? c_cur - 1'b1 : c_cur;
	assign is_run = rv_q && run_q == id_q;
	assign in_r   = q_has(rq, rcnt, id_q);
	assign in_s   = q_has(sq, scnt, id_q);
	assign slp_path = s_cur == ST_SLEEPING && intr_q[id_q] && in_s;
	assign found  = s_cur == ST_SUSPENDED || slp_path;
	assign wt     = sq[scan_q[TID_W-1:0]];
	assign out_load = state_q == S_DONE && (!ov_q || out_ready);

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		rcmd = '{op: Q_NONE, id: id_q};
		scmd = '{op: Q_NONE, id: id_q};
		st_we = 1'b0; st_wa = id_q; st_wd = ST_UNKNOWN;
		cd_we = 1'b0; cd_wa = id_q; cd_wd = '0;
		in_we = 1'b0; in_wa = id_q; in_wd = 1'b0;
		cr_we = 1'b0; cr_wd = c_cur;
		dec_all = 1'b0;
		acc_set = 1'b0; left_we = 1'b0; left_wd = '0;
		scan_inc = 1'b0; rv_clr = 1'b0; run_we = 1'b0; run_wd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
				if (req_q == REQ_TICK) begin
					state_d = S_DEC;
				end else if (req_q == REQ_RESCHED) begin
					state_d = S_WAKE;
				end else if (id_q != '0) begin
					case (req_q)
						REQ_ENABLE: begin
							if (s_cur == ST_UNKNOWN || s_cur == ST_FINALIZED) begin
								st_we = 1'b1; st_wd = ST_SUSPENDED; acc_set = 1'b1;
							end
						end
						REQ_SUSPEND: begin
							cr_we = 1'b1; cr_wd = c_dec;
							if (c_dec == '0) begin
								acc_set = 1'b1;
								if (is_run) begin
									st_we = 1'b1; st_wd = ST_SUSPENDING; state_d = S_WAKE;
								end else if (in_r) begin
									rcmd.op = Q_REMOVE; st_we = 1'b1; st_wd = ST_SUSPENDED;
								end else if (in_s) begin
									scmd.op = Q_REMOVE; st_we = 1'b1; st_wd = ST_SUSPENDED;
								end
							end
						end
						REQ_RESUME, REQ_RES_TICK: begin
							cr_we = 1'b1;
							cr_wd = (c_cur != '1) ? c_cur + 1'b1 : c_cur;
							acc_set = found;
							if (found) begin
								st_we = 1'b1; st_wd = ST_READY;
								rcmd.op = (req_q == REQ_RES_TICK || front_q) ?
									Q_PUSH_FRONT : Q_PUSH_BACK;
								if (req_q == REQ_RES_TICK)
									state_d = S_DEC;
							end
							if (s_cur != ST_SUSPENDED && slp_path) begin
								scmd.op = Q_REMOVE;
								left_we = 1'b1; left_wd = cd_q[id_q];
								in_we = 1'b1; cd_we = 1'b1;
							end
						end
						REQ_SLEEP: begin
							cr_we = 1'b1; cr_wd = c_dec;
							if (c_dec != '0) begin
								left_we = 1'b1; left_wd = ticks_q;
							end else begin
								acc_set = 1'b1;
								rcmd.op = Q_REMOVE;
								scmd.op = Q_PUSH_BACK;
								st_we = 1'b1; st_wd = ST_SLEEPING;
								cd_we = 1'b1; cd_wd = ticks_q;
								in_we = 1'b1; in_wd = irq_q;
								if (is_run)
									state_d = S_WAKE;
							end
						end
						REQ_FINALIZE: begin
							acc_set = 1'b1;
							st_we = 1'b1; st_wd = ST_FINALIZED;
							rcmd.op = Q_REMOVE;
							scmd.op = Q_REMOVE;
							if (is_run) begin
								rv_clr = 1'b1; state_d = S_WAKE;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_DEC: begin
				dec_all = 1'b1;
				state_d = S_WAKE;
			end
			S_WAKE: begin
				if (scan_q < scnt) begin
					if (cd_q[wt] == '0) begin
						scmd = '{op: Q_REMOVE, id: wt};
						rcmd = '{op: Q_PUSH_BACK, id: wt};
						st_we = 1'b1; st_wa = wt; st_wd = ST_READY;
						in_we = 1'b1; in_wa = wt;
					end else begin
						scan_inc = 1'b1;
					end
				end else begin
					state_d = S_REQ;
				end
			end
			S_REQ: begin
				state_d = S_PICK;
				if (rv_q && run_q != '0) begin
					if (st_q[run_q] == ST_ACTIVE) begin
						st_we = 1'b1; st_wa = run_q; st_wd = ST_READY;
						rcmd = '{op: Q_PUSH_BACK, id: run_q};
					end else if (st_q[run_q] == ST_SUSPENDING) begin
						st_we = 1'b1; st_wa = run_q; st_wd = ST_SUSPENDED;
					end
				end
			end
			S_PICK: begin
				state_d = S_DONE;
				run_we = 1'b1;
				if (rcnt != '0) begin
					run_wd = rq[0];
					rcmd = '{op: Q_REMOVE, id: rq[0]};
				end
				st_we = 1'b1; st_wa = run_wd; st_wd = ST_ACTIVE;
			end
			S_DONE: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_q   <= TID_W'(1);
			rv_q    <= 1'b1;
			ov_q    <= 1'b0;
			for (int t = 0; t < THREAD_COUNT; t++) begin
				st_q[t]   <= (t == 1) ? ST_ACTIVE : ST_UNKNOWN;
				cd_q[t]   <= '0;
				intr_q[t] <= 1'b0;
				cred_q[t] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (st_we)
				st_q[st_wa] <= st_wd;
			if (in_we)
				intr_q[in_wa] <= in_wd;
			if (cr_we)
				cred_q[id_q] <= cr_wd;
			if (dec_all) begin
				for (int t = 0; t < THREAD_COUNT; t++) begin
					if (q_has(sq, scnt, TID_W'(t)) && cd_q[t] != '0)
						cd_q[t] <= cd_q[t] - 1'b1;
				end
			end else if (cd_we) begin
				cd_q[cd_wa] <= cd_wd;
			end
			if (rv_clr)
				rv_q <= 1'b0;
			if (run_we) begin
				run_q <= run_wd;
				rv_q  <= 1'b1;
			end
			if (out_load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q   <= req_type;
			id_q    <= thread_id;
			front_q <= prepend;
			ticks_q <= sleep_ticks;
			irq_q   <= interruptible;
			prev_q  <= run_q;
			pv_q    <= rv_q;
			acc_q   <= 1'b0;
			left_q  <= '0;
			scan_q  <= '0;
		end else begin
			if (acc_set)
				acc_q <= 1'b1;
			if (left_we)
				left_q <= left_wd;
			if (scan_inc)
				scan_q <= scan_q + 1'b1;
		end
		if (out_load) begin
			o_run_q  <= run_q;
			o_sw_q   <= !pv_q || prev_q != run_q;
			o_acc_q  <= acc_q;
			o_left_q <= left_q;
		end
	end

	assign out_valid  = ov_q;
	assign running_id = o_run_q;
	assign switched   = o_sw_q;
	assign accepted   = o_acc_q;
	assign ticks_left = o_left_q;
endmodule

// ===== bench/thread_ready_sleep_scheduler_core_tb.sv =====
// Testbench for the thread scheduler core: drives request words, predicts each result
// word and compares it field by field. Depends on trss_pkg and the core RTL.
module thread_ready_sleep_scheduler_core_tb;
	import trss_pkg::*;

	typedef struct {
		logic [TID_W-1:0]  run_id;
		logic              sw;
		logic              acc;
		logic [TICK_W-1:0] left;
	} sched_res_t;

	// scheduler shadow: table, queues and the result words still owed
	class sched_scoreboard;
		logic [2:0]        status [THREAD_COUNT];
		logic [TICK_W-1:0] countdown [THREAD_COUNT];
		bit                intr_flag [THREAD_COUNT];
		int                credit [THREAD_COUNT];
		int                ready_q [$];
		int                sleep_q [$];
		int                cur;
		bit                cur_valid;
		sched_res_t        owed [$];
		int                errors;
		int                checked;

		function void clear();
			for (int i = 0; i < THREAD_COUNT; i++) begin
				status[i] = ST_UNKNOWN;
				countdown[i] = '0;
				intr_flag[i] = 0;
				credit[i] = 0;
			end
			ready_q.delete();
			sleep_q.delete();
			cur = 1;
			cur_valid = 1;
			status[1] = ST_ACTIVE;
			errors = 0;
			checked = 0;
		endfunction

		function bit drop(ref int q[$], input int id);
			for (int i = 0; i < q.size(); i++) begin
				if (q[i] == id) begin
					q.delete(i);
					return 1;
				end
			end
			return 0;
		endfunction

		function void push(ref int q[$], input int id, input bit front);
			void'(drop(q, id));
			if (front)
				q.push_front(id);
			else
				q.push_back(id);
		endfunction

		function void switch_over(bit tick);
			int i;
			int t;
			int nxt;
			nxt = 0;
			if (tick) begin
				foreach (sleep_q[k])
					if (countdown[sleep_q[k]] != 0)
						countdown[sleep_q[k]]--;
			end
			i = 0;
			while (i < sleep_q.size()) begin
				t = sleep_q[i];
				if (countdown[t] == 0) begin
					sleep_q.delete(i);
					status[t] = ST_READY;
					intr_flag[t] = 0;
					push(ready_q, t, 0);
				end else begin
					i++;
				end
			end
			if (cur_valid && cur != 0) begin
				if (status[cur] == ST_ACTIVE) begin
					status[cur] = ST_READY;
					push(ready_q, cur, 0);
				end else if (status[cur] == ST_SUSPENDING) begin
					status[cur] = ST_SUSPENDED;
				end
			end
			if (ready_q.size() > 0)
				nxt = ready_q.pop_front();
			cur = nxt;
			cur_valid = 1;
			status[nxt] = ST_ACTIVE;
		endfunction

		function bit wake(int id, bit front, ref logic [TICK_W-1:0] left);
			bit found;
			found = 0;
			if (credit[id] < 255)
				credit[id]++;
			if (status[id] == ST_SUSPENDED) begin
				found = 1;
			end else if (status[id] == ST_SLEEPING && intr_flag[id] && drop(sleep_q, id)) begin
				left = countdown[id];
				intr_flag[id] = 0;
				countdown[id] = '0;
				found = 1;
			end
			if (found) begin
				status[id] = ST_READY;
				push(ready_q, id, front);
			end
			return found;
		endfunction

		function void note_request(logic [2:0] req, int id, bit front,
				logic [TICK_W-1:0] ticks, bit intr);
			sched_res_t r;
			int prev;
			bit prev_valid;
			bit ok;
			prev = cur;
			prev_valid = cur_valid;
			r.acc = 0;
			r.left = '0;
			ok = id != 0;
			if (req == REQ_TICK) begin
				switch_over(1);
			end else if (req == REQ_RESCHED) begin
				switch_over(0);
			end else if (ok) begin
				case (req)
				REQ_ENABLE: begin
					if (status[id] == ST_UNKNOWN || status[id] == ST_FINALIZED) begin
						status[id] = ST_SUSPENDED;
						r.acc = 1;
					end
				end
				REQ_SUSPEND: begin
					if (credit[id] != 0)
						credit[id]--;
					if (credit[id] == 0) begin
						r.acc = 1;
						if (cur_valid && cur == id) begin
							status[id] = ST_SUSPENDING;
							switch_over(0);
						end else if (drop(ready_q, id) || drop(sleep_q, id)) begin
							status[id] = ST_SUSPENDED;
						end
					end
				end
				REQ_RESUME: r.acc = wake(id, front, r.left);
				REQ_SLEEP: begin
					if (credit[id] != 0)
						credit[id]--;
					if (credit[id] != 0) begin
						r.left = ticks;
					end else begin
						r.acc = 1;
						void'(drop(ready_q, id));
						status[id] = ST_SLEEPING;
						countdown[id] = ticks;
						intr_flag[id] = intr;
						push(sleep_q, id, 0);
						if (cur_valid && cur == id)
							switch_over(0);
					end
				end
				REQ_FINALIZE: begin
					r.acc = 1;
					status[id] = ST_FINALIZED;
					void'(drop(ready_q, id));
					void'(drop(sleep_q, id));
					if (cur_valid && cur == id) begin
						cur_valid = 0;
						switch_over(0);
					end
				end
				default: begin
					r.acc = wake(id, 1, r.left);
					if (r.acc)
						switch_over(1);
				end
				endcase
			end
			r.run_id = cur[TID_W-1:0];
			r.sw = !prev_valid || prev != cur;
			owed.push_back(r);
		endfunction

		function void check_result(sched_res_t got);
			sched_res_t e;
			checked++;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: running_id=%0d", got.run_id);
				return;
			end
			e = owed.pop_front();
			if (e.run_id !== got.run_id || e.sw !== got.sw || e.acc !== got.acc ||
					e.left !== got.left) begin
				errors++;
				if (errors <= 10)
					$display("mismatch word %0d: exp id=%0d sw=%0b acc=%0b left=%0d, got id=%0d sw=%0b acc=%0b left=%0d",
						checked, e.run_id, e.sw, e.acc, e.left,
						got.run_id, got.sw, got.acc, got.left);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        req_type;
	logic [TID_W-1:0]  thread_id;
	logic              prepend;
	logic [TICK_W-1:0] sleep_ticks;
	logic              interruptible;
	logic              out_valid;
	logic              out_ready;
	logic [TID_W-1:0]  running_id;
	logic              switched;
	logic              accepted;
	logic [TICK_W-1:0] ticks_left;

	sched_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int sent;

	thread_ready_sleep_scheduler_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .thread_id(thread_id), .prepend(prepend),
		.sleep_ticks(sleep_ticks), .interruptible(interruptible),
		.out_valid(out_valid), .out_ready(out_ready),
		.running_id(running_id), .switched(switched),
		.accepted(accepted), .ticks_left(ticks_left)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stalls, check on each accepted word
	always @(posedge clk) begin
		sched_res_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.run_id = running_id;
				got.sw = switched;
				got.acc = accepted;
				got.left = ticks_left;
				sb.check_result(got);
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// valid drops only in idle cycles, so each edge sees at most one update
	task automatic send_word(logic [2:0] req, logic [TID_W-1:0] id, logic front,
			logic [TICK_W-1:0] ticks, logic intr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		req_type <= req;
		thread_id <= id;
		prepend <= front;
		sleep_ticks <= ticks;
		interruptible <= intr;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(req, id, front, ticks, intr);
		sent++;
	endtask

	task automatic send_random();
		logic [2:0] req;
		logic [TICK_W-1:0] ticks;
		int sel;
		sel = $urandom_range(99);
		// mostly a lively mix of short sleeps, resumes and ticks
		if (sel < 20)
			req = REQ_TICK;
		else if (sel < 25)
			req = REQ_RESCHED;
		else if (sel < 37)
			req = REQ_ENABLE;
		else if (sel < 50)
			req = REQ_SUSPEND;
		else if (sel < 67)
			req = REQ_RESUME;
		else if (sel < 82)
			req = REQ_SLEEP;
		else if (sel < 88)
			req = REQ_FINALIZE;
		else
			req = REQ_RES_TICK;
		ticks = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(6);
		send_word(req, (sel % 17 == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
			$urandom_range(1), ticks, $urandom_range(1));
	endtask

	initial begin
		sb = new();
		sb.clear();
		sent = 0;
		send_idle_pct = 28;
		recv_idle_pct = 45;
		arst_n = 0;
		in_valid = 0;
		req_type = REQ_TICK;
		thread_id = '0;
		prepend = 0;
		sleep_ticks = '0;
		interruptible = 0;
		out_ready = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle target, enables, live enable, sleeps, resumes, finalize
		send_word(REQ_ENABLE, 4'd0, 0, '0, 0);
		send_word(REQ_RES_TICK, 4'd0, 1, '1, 1);
		send_word(REQ_ENABLE, 4'd2, 0, '0, 0);
		send_word(REQ_ENABLE, 4'd15, 0, '0, 0);
		send_word(REQ_ENABLE, 4'd2, 0, '0, 0);
		send_word(REQ_SUSPEND, 4'd5, 0, '0, 0);
		send_word(REQ_RESUME, 4'd2, 0, '0, 0);
		send_word(REQ_RESUME, 4'd15, 1, '0, 0);
		send_word(REQ_SLEEP, 4'd1, 0, '0, 0);
		send_word(REQ_TICK, 4'd0, 0, '0, 0);
		send_word(REQ_SLEEP, 4'd15, 0, '1, 1);
		send_word(REQ_RESUME, 4'd15, 0, '0, 0);
		send_word(REQ_SLEEP, 4'd15, 1, 32'd2, 0);
		send_word(REQ_SLEEP, 4'd15, 1, 32'd2, 0);
		send_word(REQ_RESCHED, 4'd0, 0, '0, 0);
		send_word(REQ_TICK, 4'd0, 0, '0, 0);
		send_word(REQ_TICK, 4'd0, 0, '0, 0);
		send_word(REQ_SUSPEND, 4'd2, 0, '0, 0);
		send_word(REQ_RES_TICK, 4'd2, 0, '0, 0);
		send_word(REQ_FINALIZE, 4'd2, 0, '0, 0);
		send_word(REQ_FINALIZE, 4'd15, 0, '0, 0);
		send_word(REQ_ENABLE, 4'd15, 0, '0, 0);
		send_word(REQ_RESCHED, 4'd0, 0, '0, 0);

		for (int i = 0; i < 300; i++)
			send_random();
		send_idle_pct = 45;
		recv_idle_pct = 28;
		for (int i = 0; i < 300; i++)
			send_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 300; i++)
			send_random();
		in_valid <= 0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d request words covering every request type, checked %0d results.",
			sent, sb.checked);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
